// ===== design/intel_hex_record_parser_unit_assert.svh =====
// Assertion macros used by the parser top level, intel_hex_record_parser_unit.sv.
`ifndef INTEL_HEX_RECORD_PARSER_UNIT_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IHEX_ASSERT_SAME(label, clock, resetn, cond, expr, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |-> (expr)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IHEX_ASSERT_NEXT(label, clock, resetn, cond, expr, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== design/ihex_pkg.sv =====
`timescale 1ns / 1ps

package ihex_pkg;

    localparam int TOTAL_OUT_WIDTH = 32;
    localparam int ADDRESS_WIDTH   = 17;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] DIGIT_TEN    = 8'h0A;

    localparam logic [7:0] REC_DATA       = 8'h00;
    localparam logic [7:0] REC_EOF        = 8'h01;
    localparam logic [7:0] REC_UNSUP_LOW  = 8'h02;
    localparam logic [7:0] REC_UNSUP_HIGH = 8'h05;

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_COUNT  = 3'd1,
        PH_OFFSET = 3'd2,
        PH_TYPE   = 3'd3,
        PH_DATA   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EOF   = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_TYPE  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic [ADDRESS_WIDTH-1:0]   address;
        logic [7:0]                 data_byte;
        logic [TOTAL_OUT_WIDTH-1:0] total_bytes;
    } ihex_result_t;

    typedef struct packed {
        logic push;
        logic halted;
    } ihex_core_status_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t r;
        r.valid = 1'b1;
        r.value = 4'd0;
        case (c) inside
            [CHAR_ZERO:CHAR_NINE]:       r.value = 4'(c - CHAR_ZERO);
            [CHAR_LOWER_A:CHAR_LOWER_F]: r.value = 4'(c - CHAR_LOWER_A + DIGIT_TEN);
            [CHAR_UPPER_A:CHAR_UPPER_F]: r.value = 4'(c - CHAR_UPPER_A + DIGIT_TEN);
            default:                     r.valid = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/ihex_parse_core.sv =====
`timescale 1ns / 1ps

module ihex_parse_core
    import ihex_pkg::*;
#(
    parameter int TOTAL_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        character,
    output ihex_result_t      result,
    output ihex_core_status_t status
);

    phase_t                 phase_reg, phase_next;
    logic [1:0]             digit_count_reg, digit_count_next;
    logic [3:0]             high_nibble_reg, high_nibble_next;
    logic [7:0]             remaining_reg, remaining_next;
    logic [15:0]            offset_reg, offset_next;
    logic [7:0]             rec_kind_reg, rec_kind_next;
    logic [7:0]             byte_index_reg, byte_index_next;
    logic [TOTAL_WIDTH-1:0] total_reg, total_next;
    logic                   halted_reg, halted_next;

    logic [TOTAL_OUT_WIDTH-1:0] total_low;
    hex_digit_t                 digit;
    logic [7:0]                 kind_shifted;
    logic [7:0]                 remaining_dec;
    logic                       push;

    generate
        if (TOTAL_WIDTH >= TOTAL_OUT_WIDTH)
        begin : g_wide_total
            assign total_low = total_reg[TOTAL_OUT_WIDTH-1:0];
        end
        else
        begin : g_narrow_total
            assign total_low = {{(TOTAL_OUT_WIDTH-TOTAL_WIDTH){1'b0}}, total_reg};
        end
    endgenerate

    assign digit         = hex_decode(character);
    assign kind_shifted  = {rec_kind_reg[3:0], digit.value};
    assign remaining_dec = remaining_reg - 8'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        digit_count_next = digit_count_reg;
        high_nibble_next = high_nibble_reg;
        remaining_next   = remaining_reg;
        offset_next      = offset_reg;
        rec_kind_next    = rec_kind_reg;
        byte_index_next  = byte_index_reg;
        total_next       = total_reg;
        halted_next      = halted_reg;
        push             = 1'b0;
        result           = '0;

        if (take && !halted_reg)
        begin
            if (phase_reg == PH_WAIT)
            begin
                if (character == CHAR_COLON)
                begin
                    phase_next       = PH_COUNT;
                    digit_count_next = 2'd0;
                    remaining_next   = 8'd0;
                    offset_next      = 16'd0;
                    rec_kind_next    = 8'd0;
                    byte_index_next  = 8'd0;
                end
            end
            else if (!digit.valid)
            begin
                // Any non-hex character inside a field, a colon included, is fatal.
                halted_next = 1'b1;
                push        = 1'b1;
                result.kind = KIND_BAD;
            end
            else
            begin
                case (phase_reg)
                    PH_COUNT:
                    begin
                        remaining_next = {remaining_reg[3:0], digit.value};
                        if (digit_count_reg == 2'd1)
                        begin
                            digit_count_next = 2'd0;
                            phase_next       = PH_OFFSET;
                        end
                        else
                        begin
                            digit_count_next = 2'd1;
                        end
                    end
                    PH_OFFSET:
                    begin
                        offset_next = {offset_reg[11:0], digit.value};
                        if (digit_count_reg == 2'd3)
                        begin
                            digit_count_next = 2'd0;
                            phase_next       = PH_TYPE;
                        end
                        else
                        begin
                            digit_count_next = digit_count_reg + 2'd1;
                        end
                    end
                    PH_TYPE:
                    begin
                        rec_kind_next = kind_shifted;
                        if (digit_count_reg == 2'd0)
                        begin
                            digit_count_next = 2'd1;
                        end
                        else
                        begin
                            digit_count_next = 2'd0;
                            if (kind_shifted == REC_DATA)
                            begin
                                total_next      = total_reg + TOTAL_WIDTH'(remaining_reg);
                                byte_index_next = 8'd0;
                                phase_next      = (remaining_reg == 8'd0) ? PH_WAIT : PH_DATA;
                            end
                            else if (kind_shifted == REC_EOF)
                            begin
                                halted_next        = 1'b1;
                                push               = 1'b1;
                                result.kind        = KIND_EOF;
                                result.total_bytes = total_low;
                            end
                            else if (kind_shifted >= REC_UNSUP_LOW &&
                                     kind_shifted <= REC_UNSUP_HIGH)
                            begin
                                halted_next = 1'b1;
                                push        = 1'b1;
                                result.kind = KIND_TYPE;
                            end
                            else
                            begin
                                phase_next = PH_WAIT;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        if (digit_count_reg == 2'd0)
                        begin
                            high_nibble_next = digit.value;
                            digit_count_next = 2'd1;
                        end
                        else
                        begin
                            digit_count_next = 2'd0;
                            byte_index_next  = byte_index_reg + 8'd1;
                            remaining_next   = remaining_dec;
                            if (remaining_dec == 8'd0)
                            begin
                                phase_next = PH_WAIT;
                            end
                            push             = 1'b1;
                            result.kind      = KIND_DATA;
                            result.address   = {1'b0, offset_reg} +
                                               {{(ADDRESS_WIDTH-8){1'b0}}, byte_index_reg};
                            result.data_byte = {high_nibble_reg, digit.value};
                        end
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                    end
                endcase
            end
        end

        status.push   = push;
        status.halted = halted_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT;
            digit_count_reg <= 2'd0;
            high_nibble_reg <= 4'd0;
            remaining_reg   <= 8'd0;
            offset_reg      <= 16'd0;
            rec_kind_reg    <= 8'd0;
            byte_index_reg  <= 8'd0;
            total_reg       <= '0;
            halted_reg      <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            digit_count_reg <= digit_count_next;
            high_nibble_reg <= high_nibble_next;
            remaining_reg   <= remaining_next;
            offset_reg      <= offset_next;
            rec_kind_reg    <= rec_kind_next;
            byte_index_reg  <= byte_index_next;
            total_reg       <= total_next;
            halted_reg      <= halted_next;
        end
    end

endmodule

// ===== design/ihex_out_buffer.sv =====
`timescale 1ns / 1ps

module ihex_out_buffer
    import ihex_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  ihex_result_t push_data,
    output logic         full,
    output logic         out_valid,
    input  logic         out_stall,
    output ihex_result_t out_data
);

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    ihex_result_t main_reg, main_next;
    ihex_result_t skid_reg, skid_next;

    // The producer only pushes while the skid slot is empty.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;

        if (!main_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = push;
                skid_next       = push_data;
            end
            else
            begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

// ===== design/intel_hex_record_parser_unit.sv =====
// Intel HEX record parser: takes one text character per cycle while in_stall
// is low and, for each character, gives at most one result (data byte with
// address, end of file with the total data byte count, or an error). Text
// before a colon is skipped; checksums are not checked. A character is taken
// in every cycle while in_stall is low, and its result is registered in the
// output buffer. The rate is set by the parser state register, updated once
// per character; a two-entry output buffer lets input continue while a
// result waits, and in_stall rises only when both entries are occupied.
// After end of file or any error the parser ignores all input until reset.
`timescale 1ns / 1ps

`include "intel_hex_record_parser_unit_assert.svh"

module intel_hex_record_parser_unit
    import ihex_pkg::*;
#(
    parameter int TOTAL_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  character,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [16:0] address,
    output logic [7:0]  data_byte,
    output logic [31:0] total_bytes
);

    logic              take;
    logic              buffer_full;
    ihex_result_t      core_result;
    ihex_core_status_t core_status;
    ihex_result_t      out_data;

    assign take     = in_valid && !buffer_full;
    assign in_stall = buffer_full;

    ihex_parse_core #(
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .character (character),
        .result    (core_result),
        .status    (core_status)
    );

    ihex_out_buffer u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_status.push),
        .push_data (core_result),
        .full      (buffer_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind        = out_data.kind;
    assign address     = out_data.address;
    assign data_byte   = out_data.data_byte;
    assign total_bytes = out_data.total_bytes;

    `IHEX_ASSERT_SAME(a_full_has_output, clk, rst_n, buffer_full, out_valid,
        "output buffer holds a result in the skid slot but none at the output")
    `IHEX_ASSERT_SAME(a_no_push_halted, clk, rst_n, core_status.halted, !core_status.push,
        "parser produced a result after halting")
    `IHEX_ASSERT_NEXT(a_eof_halts, clk, rst_n,
        core_status.push && (core_result.kind == KIND_EOF), core_status.halted,
        "end of file did not halt the parser")
    `IHEX_ASSERT_NEXT(a_push_shows, clk, rst_n, core_status.push, out_valid,
        "a transfer into the output buffer was lost")

endmodule

// ===== sim/tb_intel_hex_record_parser_unit.sv =====
`timescale 1ns / 1ps

module tb_intel_hex_record_parser_unit;
    import ihex_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_CHARS   = 900;

    // How the stream is brought to its end: the parser halts for good on any of these.
    typedef enum int {
        END_EOF,
        END_UNSUPPORTED,
        END_BAD_COUNT,
        END_BAD_OFFSET,
        END_BAD_TYPE,
        END_BAD_DATA,
        END_COLON_IN_FIELD
    } ending_t;

    class hex_stream_scoreboard;
        phase_t       phase       = PH_WAIT;
        logic [1:0]   digit_count = '0;
        logic [3:0]   high_nibble = '0;
        logic [7:0]   bytes_left  = '0;
        logic [15:0]  record_base = '0;
        logic [7:0]   record_type = '0;
        logic [7:0]   byte_index  = '0;
        logic [31:0]  byte_total  = '0;
        bit           halted      = 1'b0;
        ihex_result_t expected_results[$];
        int           error_count = 0;

        static function bit is_hex_digit(logic [7:0] c);
            return (c >= CHAR_ZERO && c <= CHAR_NINE)
                || (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
                || (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F);
        endfunction

        function void push_result(kind_t k, logic [16:0] a, logic [7:0] d, logic [31:0] t);
            ihex_result_t r;
            r.kind        = k;
            r.address     = a;
            r.data_byte   = d;
            r.total_bytes = t;
            expected_results.push_back(r);
        endfunction

        // Advances the parser state by one accepted character.
        function void parse_character(logic [7:0] c);
            logic [3:0] d;
            if (halted)
                return;
            if (phase == PH_WAIT)
            begin
                if (c == CHAR_COLON)
                begin
                    phase       = PH_COUNT;
                    digit_count = '0;
                    bytes_left  = '0;
                    record_base = '0;
                    record_type = '0;
                    byte_index  = '0;
                end
                return;
            end
            if (!is_hex_digit(c))
            begin
                halted = 1'b1;
                push_result(KIND_BAD, '0, '0, '0);
                return;
            end
            if (c <= CHAR_NINE)
                d = 4'(c - CHAR_ZERO);
            else if (c <= CHAR_UPPER_F)
                d = 4'(c - CHAR_UPPER_A) + 4'd10;
            else
                d = 4'(c - CHAR_LOWER_A) + 4'd10;

            case (phase)
                PH_COUNT:
                begin
                    bytes_left = {bytes_left[3:0], d};
                    if (digit_count == 2'd1)
                    begin
                        digit_count = '0;
                        phase       = PH_OFFSET;
                    end
                    else
                        digit_count = 2'd1;
                end
                PH_OFFSET:
                begin
                    record_base = {record_base[11:0], d};
                    if (digit_count == 2'd3)
                        phase = PH_TYPE;
                    // The two-bit counter wraps back to zero after the fourth digit.
                    digit_count = digit_count + 2'd1;
                end
                PH_TYPE:
                begin
                    record_type = {record_type[3:0], d};
                    if (digit_count == 2'd0)
                        digit_count = 2'd1;
                    else
                    begin
                        digit_count = '0;
                        if (record_type == REC_DATA)
                        begin
                            byte_total = byte_total + {24'h0, bytes_left};
                            byte_index = '0;
                            if (bytes_left == '0)
                                phase = PH_WAIT;
                            else
                                phase = PH_DATA;
                        end
                        else if (record_type == REC_EOF)
                        begin
                            halted = 1'b1;
                            push_result(KIND_EOF, '0, '0, byte_total);
                        end
                        else if (record_type >= REC_UNSUP_LOW && record_type <= REC_UNSUP_HIGH)
                        begin
                            halted = 1'b1;
                            push_result(KIND_TYPE, '0, '0, '0);
                        end
                        else
                            phase = PH_WAIT;
                    end
                end
                PH_DATA:
                begin
                    if (digit_count == 2'd0)
                    begin
                        high_nibble = d;
                        digit_count = 2'd1;
                    end
                    else
                    begin
                        digit_count = '0;
                        push_result(KIND_DATA, {1'b0, record_base} + {9'h0, byte_index},
                                    {high_nibble, d}, '0);
                        byte_index = byte_index + 8'd1;
                        bytes_left = bytes_left - 8'd1;
                        if (bytes_left == '0)
                            phase = PH_WAIT;
                    end
                end
                default: phase = PH_WAIT;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %h, got %h", name, want, got);
                error_count++;
            end
        endfunction

        function void check_result(logic [1:0] k, logic [16:0] a, logic [7:0] d,
                                   logic [31:0] t);
            ihex_result_t want;
            if (expected_results.size() == 0)
            begin
                $error({"result with nothing expected: ",
                        "kind %0d address %h data_byte %h total_bytes %h"},
                       k, a, d, t);
                error_count++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("kind", 32'(want.kind), 32'(k));
            compare_field("address", 32'(want.address), 32'(a));
            compare_field("data_byte", 32'(want.data_byte), 32'(d));
            compare_field("total_bytes", want.total_bytes, t);
        endfunction

        function int pending_count();
            return expected_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  character   = 8'h00;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [1:0]  kind;
    logic [16:0] address;
    logic [7:0]  data_byte;
    logic [31:0] total_bytes;

    hex_stream_scoreboard sb = new();
    logic [7:0]           text_stream[$];
    bit                   steady_tail    = 1'b0;
    int                   stall_left     = 0;
    int                   stalled_cycles = 0;

    intel_hex_record_parser_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .character   (character),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .address     (address),
        .data_byte   (data_byte),
        .total_bytes (total_bytes)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return CHAR_ZERO + {4'h0, n};
        else if ($urandom_range(0, 1) == 0)
            return CHAR_UPPER_A + {4'h0, n - 4'd10};
        else
            return CHAR_LOWER_A + {4'h0, n - 4'd10};
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (hex_stream_scoreboard::is_hex_digit(c));
        return c;
    endfunction

    task automatic put_hex(input logic [15:0] value, input int digits);
        for (int i = digits - 1; i >= 0; i--)
            text_stream.push_back(hex_char(value[4*i +: 4]));
    endtask

    // Text between records; a colon here would open a record.
    task automatic put_noise(input int n);
        logic [7:0] c;
        repeat (n)
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == CHAR_COLON);
            text_stream.push_back(c);
        end
    endtask

    task automatic put_record(input logic [7:0] rtype, input logic [7:0] count,
                              input logic [15:0] base, input int body_len);
        text_stream.push_back(CHAR_COLON);
        put_hex({8'h00, count}, 2);
        put_hex(base, 4);
        put_hex({8'h00, rtype}, 2);
        repeat (body_len)
            put_hex(16'($urandom_range(0, 255)), 2);
        // The checksum is never verified, so any value will do.
        put_hex(16'($urandom_range(0, 255)), 2);
    endtask

    task automatic add_random_records(input int target);
        int          pick;
        logic [7:0]  count;
        logic [15:0] base;
        while (text_stream.size() < target)
        begin
            pick = $urandom_range(0, 99);
            base = 16'($urandom);
            if (pick < 10)
                base = 16'hFFFF - 16'($urandom_range(0, 3));
            else if (pick < 15)
                base = '0;
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    count = '0;
                else if (pick < 92)
                    count = 8'($urandom_range(1, 16));
                else if (pick < 98)
                    count = 8'($urandom_range(17, 64));
                else
                begin
                    count = 8'hFF;
                    if ($urandom_range(0, 1) == 0)
                        base = 16'hFFFF;
                end
                put_record(REC_DATA, count, base, int'(count));
            end
            else
                put_record(8'($urandom_range(REC_UNSUP_HIGH + 1, 255)),
                           8'($urandom_range(0, 255)), base, $urandom_range(0, 8));
            put_noise($urandom_range(0, 3));
        end
    endtask

    task automatic add_ending();
        ending_t    ending;
        int         start;
        int         first;
        int         last;
        logic [7:0] count;
        ending = ending_t'($urandom_range(0, END_COLON_IN_FIELD));
        count  = 8'($urandom_range(1, 8));
        start  = text_stream.size();
        case (ending)
            END_EOF:
                put_record(REC_EOF, 8'($urandom_range(0, 255)), 16'($urandom), 0);
            END_UNSUPPORTED:
                put_record(8'($urandom_range(REC_UNSUP_LOW, REC_UNSUP_HIGH)), count,
                           16'($urandom), int'(count));
            default:
            begin
                put_record(REC_DATA, count, 16'($urandom), int'(count));
                // Digit positions after the colon: count 1-2, offset 3-6, type 7-8, data from 9.
                case (ending)
                    END_BAD_COUNT:
                    begin
                        first = 1;
                        last  = 2;
                    end
                    END_BAD_OFFSET:
                    begin
                        first = 3;
                        last  = 6;
                    end
                    END_BAD_TYPE:
                    begin
                        first = 7;
                        last  = 8;
                    end
                    END_BAD_DATA:
                    begin
                        first = 9;
                        last  = 8 + 2 * int'(count);
                    end
                    default:
                    begin
                        first = 1;
                        last  = 8 + 2 * int'(count);
                    end
                endcase
                if (ending == END_COLON_IN_FIELD)
                    text_stream[start + $urandom_range(first, last)] = CHAR_COLON;
                else
                    text_stream[start + $urandom_range(first, last)] = non_hex_char();
            end
        endcase
        // The parser is halted from here on, so none of this may produce anything.
        put_noise(4);
        put_record(REC_DATA, 8'd2, 16'h0100, 2);
        text_stream.push_back(CHAR_COLON);
        put_record(REC_EOF, 8'd0, 16'h0000, 0);
    endtask

    task automatic send_char(input logic [7:0] c);
        if (!steady_tail && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        character <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Both transfers are observed here, input first, so the expectation for a
    // character always exists before its result can be checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.parse_character(character);
            if (out_valid && !out_stall)
                sb.check_result(kind, address, data_byte, total_bytes);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles == WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (!steady_tail && $urandom_range(0, 11) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 18);
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        int directed_len;
        int tail_start;

        // Top-bit and zero characters before any colon must be skipped.
        text_stream.push_back(8'h00);
        text_stream.push_back(8'hFF);
        // The second byte of this record lands above the 16-bit offset range.
        put_record(REC_DATA, 8'd2, 16'hFFFF, 2);
        // An empty data record gives nothing and waits for the next colon.
        put_record(REC_DATA, 8'd0, 16'h1234, 0);
        directed_len = text_stream.size();

        add_random_records(directed_len + RANDOM_CHARS);
        add_ending();
        tail_start = text_stream.size() * 85 / 100;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (text_stream[idx])
        begin
            if (idx == directed_len)
            begin
                // Hold the sender back until the directed part has fully drained.
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (sb.pending_count() != 0);
            end
            if (idx == tail_start)
                steady_tail = 1'b1;
            send_char(text_stream[idx]);
        end
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (sb.pending_count() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.error_count == 0 && sb.pending_count() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
